// ===== src/sqt_pkg.sv =====
`default_nettype none

package sqt_pkg;

  localparam int SQT_DEPTH_DEF = 256;
  localparam int VALUE_W       = 64;
  localparam int POS_W         = 16;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH      = 3'd0,
    KIND_POP       = 3'd1,
    KIND_READ_POS  = 3'd2,
    KIND_FIND      = 3'd3,
    KIND_DEL_POS   = 3'd4,
    KIND_DEL_VALUE = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_POP_EMPTY   = 3'd1,
    ST_READ_RANGE  = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_DELETE_FAIL = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_READ_WAIT,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== src/sqt_ram.sv =====
`default_nettype none

module sqt_ram
  import sqt_pkg::*;
#(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = SQT_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sqt_seq.sv =====
`default_nettype none

module sqt_seq
  import sqt_pkg::*;
#(
  parameter int QUEUE_DEPTH = SQT_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [KIND_W-1:0]                in_kind,
  input  wire logic signed [VALUE_W-1:0]        in_operand_value,
  input  wire logic [POS_W-1:0]                 in_operand_position,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [STATUS_W-1:0]                   out_status,
  output logic signed [VALUE_W-1:0]             out_result_value,
  output logic                                  ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]        ram_waddr,
  output logic [VALUE_W-1:0]                    ram_wdata,
  output logic                                  ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]        ram_raddr,
  input  wire logic [VALUE_W-1:0]               ram_rdata
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // offset from head to physical slot, wrapping at the store depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t                      state_r, state_nxt;
  kind_t                       kind_r, kind_nxt;
  logic signed [VALUE_W-1:0]   val_r, val_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]               wr_idx_r, wr_idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [CW-1:0]               pend_idx_r, pend_idx_nxt;
  status_t                     res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]          res_value_r, res_value_nxt;
  logic                        out_valid_r, out_valid_nxt;
  status_t                     out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]          out_value_r, out_value_nxt;

  logic                        pos_beyond;
  logic [CW-1:0]               pos_off;
  logic                        hit;
  logic                        out_free;

  assign pos_beyond = CMPW'(pos_r) > CMPW'(count_r);
  assign pos_off    = CW'(pos_r - POS_W'(1));
  assign hit        = pend_r && (ram_rdata == val_r);
  assign out_free   = !out_valid_r || !out_stall;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          val_nxt   = in_operand_value;
          pos_nxt   = (in_operand_position == '0) ? POS_W'(1) : in_operand_position;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_value_nxt = '0;
        case (kind_r)
          KIND_PUSH: begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_of(head_r, count_r);
              ram_wdata = val_r;
              count_nxt = count_r + CW'(1);
              state_nxt = S_IDLE;
            end
          end
          KIND_POP: begin
            if (count_r == '0) begin
              res_status_nxt = ST_POP_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_POP_WAIT;
            end
          end
          KIND_READ_POS: begin
            if (pos_beyond) begin
              res_status_nxt = ST_READ_RANGE;
              state_nxt      = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(head_r, pos_off);
              state_nxt = S_READ_WAIT;
            end
          end
          KIND_FIND, KIND_DEL_VALUE: begin
            if (count_r == '0) begin
              res_status_nxt = (kind_r == KIND_FIND) ? ST_NOT_FOUND : ST_DELETE_FAIL;
              state_nxt      = S_EMIT;
            end else begin
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          KIND_DEL_POS: begin
            if (pos_beyond) begin
              res_status_nxt = ST_DELETE_FAIL;
              state_nxt      = S_EMIT;
            end else begin
              wr_idx_nxt = pos_off;
              rd_idx_nxt = pos_off + CW'(1);
              pend_nxt   = 1'b0;
              state_nxt  = S_SHIFT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_POP_WAIT: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = ram_rdata;
        head_nxt       = slot_of(head_r, CW'(1));
        count_nxt      = count_r - CW'(1);
        state_nxt      = S_EMIT;
      end

      S_READ_WAIT: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = ram_rdata;
        state_nxt      = S_EMIT;
      end

      // one read issued per cycle, compare lands in the following cycle
      S_SCAN: begin
        if (hit) begin
          pend_nxt = 1'b0;
          if (kind_r == KIND_FIND) begin
            res_status_nxt = ST_OK;
            res_value_nxt  = VALUE_W'(pend_idx_r) + VALUE_W'(1);
            state_nxt      = S_EMIT;
          end else begin
            wr_idx_nxt = pend_idx_r;
            rd_idx_nxt = pend_idx_r + CW'(1);
            state_nxt  = S_SHIFT;
          end
        end else if (pend_r && pend_idx_r == count_r - CW'(1)) begin
          pend_nxt       = 1'b0;
          res_status_nxt = (kind_r == KIND_FIND) ? ST_NOT_FOUND : ST_DELETE_FAIL;
          res_value_nxt  = '0;
          state_nxt      = S_EMIT;
        end else if (rd_idx_r < count_r) begin
          ram_re       = 1'b1;
          ram_raddr    = slot_of(head_r, rd_idx_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // move entry j+1 into j; the write trails the read by two slots, so no overlap
      S_SHIFT: begin
        if (pend_r) begin
          ram_we     = 1'b1;
          ram_waddr  = slot_of(head_r, wr_idx_r);
          ram_wdata  = ram_rdata;
          wr_idx_nxt = wr_idx_r + CW'(1);
        end
        if (rd_idx_r < count_r) begin
          ram_re     = 1'b1;
          ram_raddr  = slot_of(head_r, rd_idx_r);
          rd_idx_nxt = rd_idx_r + CW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/searchable_queue_table_top.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall    in_kind, in_operand_value, in_operand_position
// out_     output     out_valid / out_stall  out_status, out_result_value
//
// One command at a time. Push passes through decode and writes the entry; pop and
// read add a RAM wait state and the emit state. Find and delete walk the entries
// through the single RAM read port, one entry per cycle.
// Synchronous active-low reset clears head, count and handshake state; the entry RAM
// is not cleared, no slot is read before it is written.
// A result waiting under out_stall does not block the next command; only a second
// result waits until the output register frees up.
`default_nettype none

module searchable_queue_table_top
  import sqt_pkg::*;
#(
  parameter int QUEUE_DEPTH = SQT_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic signed [VALUE_W-1:0] in_operand_value,
  input  wire logic [POS_W-1:0]          in_operand_position,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [STATUS_W-1:0]            out_status,
  output logic signed [VALUE_W-1:0]      out_result_value
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  sqt_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_operand_value   (in_operand_value),
    .in_operand_position(in_operand_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_value   (out_result_value),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata)
  );

  sqt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/sqt_checker.sv =====
`default_nettype none

module sqt_port_props
  import sqt_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [STATUS_W-1:0]       out_status,
  input wire logic signed [VALUE_W-1:0] out_result_value
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_result_value))
    else $error("result changed while stalled");

  // error results always carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0)
    else $error("error result with nonzero value");

  // every command passes through decode before the next is taken
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("back-to-back command acceptance");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind searchable_queue_table_top sqt_port_props u_sqt_port_props (.*);

`default_nettype wire

// ===== sim/sqt_checker.sv =====
`default_nettype none

module sqt_checker
  import sqt_pkg::*;
#(
  parameter int QUEUE_DEPTH = SQT_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic signed [VALUE_W-1:0] in_operand_value,
  input  wire logic [POS_W-1:0]          in_operand_position,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [STATUS_W-1:0]       out_status,
  input  wire logic signed [VALUE_W-1:0] out_result_value,
  output int                             mismatch_count,
  output int                             pending_replies
);

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value;
  } queue_reply_t;

  // Live entries, head first
  logic [VALUE_W-1:0] held_values[$];
  queue_reply_t       awaited_replies[$];

  task automatic flag_mismatch(input string what, input queue_reply_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected status %0d value %h, got status %0d value %h",
               what, want.status, want.value, out_status, out_result_value);
    end
  endtask

  task automatic run_command(input logic [KIND_W-1:0] kind,
                             input logic [VALUE_W-1:0] operand,
                             input logic [POS_W-1:0] position);
    int           pos;
    int           match_idx;
    int           k;
    bit           has_reply;
    queue_reply_t reply;
    pos = (position == '0) ? 1 : int'(position);
    has_reply = 1'b0;
    reply.status = ST_OK;
    reply.value = '0;
    match_idx = -1;
    for (k = 0; k < held_values.size(); k++) begin
      if (match_idx < 0 && held_values[k] == operand) match_idx = k;
    end
    case (kind)
      KIND_PUSH: begin
        if (held_values.size() >= QUEUE_DEPTH) begin
          reply.status = ST_FULL;
          has_reply = 1'b1;
        end else begin
          held_values.push_back(operand);
        end
      end
      KIND_POP: begin
        has_reply = 1'b1;
        if (held_values.size() == 0) reply.status = ST_POP_EMPTY;
        else reply.value = held_values.pop_front();
      end
      KIND_READ_POS: begin
        has_reply = 1'b1;
        if (pos > held_values.size()) reply.status = ST_READ_RANGE;
        else reply.value = held_values[pos-1];
      end
      KIND_FIND: begin
        has_reply = 1'b1;
        if (match_idx < 0) reply.status = ST_NOT_FOUND;
        else reply.value = VALUE_W'(match_idx + 1);
      end
      KIND_DEL_POS: begin
        if (pos > held_values.size()) begin
          reply.status = ST_DELETE_FAIL;
          has_reply = 1'b1;
        end else begin
          held_values.delete(pos - 1);
        end
      end
      KIND_DEL_VALUE: begin
        if (match_idx < 0) begin
          reply.status = ST_DELETE_FAIL;
          has_reply = 1'b1;
        end else begin
          held_values.delete(match_idx);
        end
      end
      default: ;  // unused kinds are dropped
    endcase
    if (has_reply) awaited_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst_n) begin
      held_values.delete();
      awaited_replies.delete();
      mismatch_count = 0;
    end else begin
      // retire results first so a same-edge command cannot be matched early
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          want = '0;
          flag_mismatch("unexpected result", want);
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status || out_result_value !== want.value)
            flag_mismatch("result mismatch", want);
        end
      end
      if (in_valid && !in_stall)
        run_command(in_kind, in_operand_value, in_operand_position);
    end
    pending_replies = awaited_replies.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_searchable_queue_table_top.sv =====
`default_nettype none

module tb_searchable_queue_table_top;
  import sqt_pkg::*;

  localparam int QUEUE_DEPTH    = SQT_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 460;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam int PHASE_GROW   = 0;
  localparam int PHASE_SHRINK = 1;
  localparam int PHASE_MIXED  = 2;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind;
  logic signed [VALUE_W-1:0] in_operand_value;
  logic [POS_W-1:0]          in_operand_position;
  logic                      out_valid;
  logic                      out_stall;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_result_value;

  int mismatch_count;
  int pending_replies;
  bit quiet_input;

  logic [VALUE_W-1:0] value_pool[12];

  searchable_queue_table_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_operand_value   (in_operand_value),
    .in_operand_position(in_operand_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_value   (out_result_value)
  );

  sqt_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_operand_value   (in_operand_value),
    .in_operand_position(in_operand_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_value   (out_result_value),
    .mismatch_count     (mismatch_count),
    .pending_replies    (pending_replies)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet_input || roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(11)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return POS_W'($urandom_range(40));
    if (roll < 80) return POS_W'($urandom_range(300));
    return POS_W'($urandom);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input int phase);
    int roll;
    roll = $urandom_range(99);
    case (phase)
      PHASE_GROW: begin
        if (roll < 55) return KIND_PUSH;
        if (roll < 63) return KIND_POP;
        if (roll < 75) return KIND_READ_POS;
        if (roll < 85) return KIND_FIND;
        if (roll < 92) return KIND_DEL_POS;
        if (roll < 98) return KIND_DEL_VALUE;
      end
      PHASE_SHRINK: begin
        if (roll < 20) return KIND_PUSH;
        if (roll < 45) return KIND_POP;
        if (roll < 55) return KIND_READ_POS;
        if (roll < 65) return KIND_FIND;
        if (roll < 80) return KIND_DEL_POS;
        if (roll < 98) return KIND_DEL_VALUE;
      end
      default: begin
        if (roll < 35) return KIND_PUSH;
        if (roll < 50) return KIND_POP;
        if (roll < 65) return KIND_READ_POS;
        if (roll < 78) return KIND_FIND;
        if (roll < 88) return KIND_DEL_POS;
        if (roll < 98) return KIND_DEL_VALUE;
      end
    endcase
    return $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
  endfunction

  // Called after the clock rises; returns once the command has been accepted.
  task automatic send_command(input logic [KIND_W-1:0] kind,
                              input logic [VALUE_W-1:0] operand,
                              input logic [POS_W-1:0] position);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_kind             <= kind;
    in_operand_value    <= operand;
    in_operand_position <= position;
    do @(posedge clk); while (in_stall);
  endtask

  // Result-side backpressure: short random stalls, a few long ones, quiet stretches
  initial begin
    int roll;
    int len;
    logic level;
    out_stall = 1'b0;
    forever begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        level = 1'b0;
        len = $urandom_range(150, 50);
      end else if (roll < 70) begin
        level = $urandom_range(1);
        len = $urandom_range(3, 1);
      end else if (roll < 90) begin
        level = 1'b1;
        len = $urandom_range(10, 4);
      end else begin
        level = 1'b1;
        len = $urandom_range(40, 20);
      end
      @(posedge clk);
      out_stall <= level;
      repeat (len - 1) @(posedge clk);
    end
  end

  // Ends the run if no transaction moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                 i;
    int                 phase;
    int                 phase_len;
    int                 random_items;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] deep_value;
    logic [VALUE_W-1:0] fill_value;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = KIND_PUSH;
    in_operand_value    = '0;
    in_operand_position = '0;
    quiet_input         = 1'b0;
    deep_value          = '0;

    value_pool[0] = 64'h8000_0000_0000_0000;
    value_pool[1] = 64'h7fff_ffff_ffff_ffff;
    value_pool[2] = '0;
    value_pool[3] = '1;
    value_pool[4] = 64'd1;
    for (i = 5; i < 12; i++) value_pool[i] = {$urandom, $urandom};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-queue errors and unused kinds
    send_command(KIND_POP, '0, '0);
    send_command(KIND_READ_POS, '0, '0);
    send_command(KIND_FIND, '0, '0);
    send_command(KIND_DEL_POS, '0, 16'd1);
    send_command(KIND_DEL_VALUE, '0, '0);
    send_command(KIND_SPARE_A, value_pool[1], 16'hffff);
    send_command(KIND_SPARE_B, value_pool[0], 16'd1);
    // extremes, with a duplicate to check find picks the first match
    send_command(KIND_PUSH, value_pool[0], '0);
    send_command(KIND_PUSH, value_pool[1], '0);
    send_command(KIND_PUSH, value_pool[2], '0);
    send_command(KIND_PUSH, value_pool[3], '0);
    send_command(KIND_PUSH, value_pool[1], '0);
    send_command(KIND_READ_POS, '0, '0);
    send_command(KIND_READ_POS, '0, 16'd1);
    send_command(KIND_READ_POS, '0, 16'd5);
    send_command(KIND_READ_POS, '0, 16'd6);
    send_command(KIND_READ_POS, '0, 16'hffff);
    send_command(KIND_FIND, value_pool[1], '0);
    send_command(KIND_FIND, 64'd12345, '0);
    // position zero removes the head
    send_command(KIND_DEL_POS, '0, '0);
    send_command(KIND_DEL_POS, '0, 16'hffff);
    send_command(KIND_DEL_VALUE, value_pool[3], '0);
    send_command(KIND_DEL_VALUE, 64'd7, '0);
    send_command(KIND_POP, '0, '0);

    // fill past capacity, then work at the deep end
    for (i = 0; i < QUEUE_DEPTH + 2; i++) begin
      fill_value = pick_value(30);
      if (i == QUEUE_DEPTH - 3) begin
        fill_value = {$urandom, $urandom};
        deep_value = fill_value;
      end
      send_command(KIND_PUSH, fill_value, pick_position());
    end
    send_command(KIND_FIND, deep_value, '0);
    send_command(KIND_READ_POS, '0, 16'(QUEUE_DEPTH));
    send_command(KIND_READ_POS, '0, 16'(QUEUE_DEPTH + 1));
    send_command(KIND_DEL_POS, '0, 16'(QUEUE_DEPTH));
    send_command(KIND_PUSH, value_pool[4], '0);
    send_command(KIND_READ_POS, '0, 16'(QUEUE_DEPTH));
    send_command(KIND_FIND, value_pool[4], '0);
    send_command(KIND_DEL_VALUE, deep_value, '0);
    for (i = 0; i < 150; i++) send_command(KIND_POP, '0, '0);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase       = $urandom_range(PHASE_MIXED);
      phase_len   = $urandom_range(120, 20);
      quiet_input = ($urandom_range(3) == 0);
      for (int j = 0; j < phase_len && random_items < RANDOM_ITEMS; j++) begin
        kind = pick_kind(phase);
        send_command(kind, pick_value(kind == KIND_PUSH ? 50 : 70), pick_position());
        if (kind != KIND_SPARE_A && kind != KIND_SPARE_B) random_items++;
      end
    end
    in_valid <= 1'b0;
    // let the checker register the last accepted command
    @(posedge clk);

    while (pending_replies != 0) @(posedge clk);
    // a trailing delete may still be walking the store
    repeat (QUEUE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_replies == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
